/* hdl/pcrc_pkg.sv */
`timescale 1ns / 1ps

package pcrc_pkg;

   localparam int QueueDepth = 4;
   localparam int PtrBits    = $clog2(QueueDepth);
   localparam int CountBits  = PtrBits + 1;

   // Clarke gains, Q14
   localparam logic signed [15:0] CLARKE_K1 = 16'sd9459;
   localparam logic signed [15:0] CLARKE_K2 = 16'sd18919;

   // register indexes
   localparam logic [2:0] CSR_SHUNT_COUNT = 3'd0;
   localparam logic [2:0] CSR_U_OFFSET    = 3'd1;
   localparam logic [2:0] CSR_V_OFFSET    = 3'd2;
   localparam logic [2:0] CSR_W_OFFSET    = 3'd3;
   localparam logic [2:0] CSR_BUS_OFFSET  = 3'd4;
   localparam logic [2:0] CSR_BUS_TRIM    = 3'd5;
   localparam logic [2:0] CSR_FIRST_TRIM  = 3'd6;
   localparam logic [2:0] CSR_STEP_LIMIT  = 3'd7;

   // shunt modes
   localparam logic [1:0] SHUNT_NONE   = 2'd0;
   localparam logic [1:0] SHUNT_SINGLE = 2'd1;
   localparam logic [1:0] SHUNT_TWO    = 2'd2;
   localparam logic [1:0] SHUNT_THREE  = 2'd3;

   // PWM sectors
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   // work handed from the front to the back
   typedef struct packed {
      logic               sampling_on;
      logic signed [15:0] i_u;
      logic signed [15:0] i_v;
      logic signed [15:0] i_w;
      logic signed [15:0] d_current;
      logic signed [15:0] q_current;
      logic signed [15:0] sine;
      logic signed [15:0] cosine;
   } mid_type;

   typedef struct packed {
      logic signed [15:0] i_alpha;
      logic signed [15:0] i_beta;
      logic signed [15:0] i_u;
      logic signed [15:0] i_v;
      logic signed [15:0] i_w;
   } rsp_type;

   // step towards target, at most lim either way (16-bit wrap)
   function automatic logic [15:0] slew(input logic [15:0] target,
                                        input logic [15:0] old,
                                        input logic [14:0] lim);
      logic        [15:0] diff;
      logic signed [16:0] diff_s;
      logic signed [16:0] lim_s;
      logic        [15:0] result;
      diff   = target - old;
      diff_s = {diff[15], diff};
      lim_s  = {2'b00, lim};
      if (diff_s > lim_s) begin
         result = old + {1'b0, lim};
      end else if (diff_s < -lim_s) begin
         result = old - {1'b0, lim};
      end else begin
         result = target;
      end
      return result;
   endfunction

endpackage

/* hdl/pcrc_mid_queue.sv */
`timescale 1ns / 1ps

module pcrc_mid_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pcrc_pkg::mid_type push_data,
   output logic             full,
   input  logic             pop,
   output pcrc_pkg::mid_type pop_data,
   output logic             empty
);
   import pcrc_pkg::*;

   mid_type               mem_ff [QueueDepth];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountBits'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CountBits'(do_push) - CountBits'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/pcrc_front.sv */
`timescale 1ns / 1ps

module pcrc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               accept,
   input  logic               req_sampling_on,
   input  logic [11:0]        req_adc_u,
   input  logic [11:0]        req_adc_v,
   input  logic [11:0]        req_adc_w,
   input  logic [11:0]        req_adc_bus_first,
   input  logic [11:0]        req_adc_bus_second,
   input  logic [2:0]         req_sector,
   input  logic signed [15:0] req_d_current,
   input  logic signed [15:0] req_q_current,
   input  logic signed [15:0] req_sine,
   input  logic signed [15:0] req_cosine,
   output pcrc_pkg::mid_type  mid_data
);
   import pcrc_pkg::*;

   logic [1:0]  shunt_count_ff;
   logic [15:0] u_offset_ff, v_offset_ff, w_offset_ff, bus_offset_ff;
   logic [15:0] bus_trim_ff, first_trim_ff;
   logic [14:0] step_limit_ff;

   logic [15:0] phase_u_ff, phase_u_in;
   logic [15:0] phase_v_ff, phase_v_in;
   logic [15:0] phase_w_ff, phase_w_in;
   logic [2:0]  delayed_sector_ff, delayed_sector_in;

   logic [15:0] iu, iv, iw;
   logic [15:0] t0, t1, a, b, c;
   logic [15:0] nu, nv, nw;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shunt_count_ff <= SHUNT_THREE;
         u_offset_ff    <= '0;
         v_offset_ff    <= '0;
         w_offset_ff    <= '0;
         bus_offset_ff  <= '0;
         bus_trim_ff    <= 16'd300;
         first_trim_ff  <= 16'hff9c;
         step_limit_ff  <= 15'd512;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SHUNT_COUNT: shunt_count_ff <= csr_data[1:0];
            CSR_U_OFFSET:    u_offset_ff    <= csr_data;
            CSR_V_OFFSET:    v_offset_ff    <= csr_data;
            CSR_W_OFFSET:    w_offset_ff    <= csr_data;
            CSR_BUS_OFFSET:  bus_offset_ff  <= csr_data;
            CSR_BUS_TRIM:    bus_trim_ff    <= csr_data;
            CSR_FIRST_TRIM:  first_trim_ff  <= csr_data;
            CSR_STEP_LIMIT:  step_limit_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // phase shunts: offset minus sample, samples scaled by sixteen
      iu = u_offset_ff - {req_adc_u, 4'b0000};
      iv = v_offset_ff - {req_adc_v, 4'b0000};
      iw = w_offset_ff - {req_adc_w, 4'b0000};

      // bus shunt
      t0 = {req_adc_bus_first, 4'b0000} - bus_offset_ff - bus_trim_ff;
      t1 = {req_adc_bus_second, 4'b0000} - bus_offset_ff - bus_trim_ff;
      a  = t0 - first_trim_ff;
      b  = 16'd0 - t1;
      c  = t1 - t0;
      nu = '0;
      nv = '0;
      nw = '0;
      case (delayed_sector_ff)
         SECTOR_1: begin nv = a; nw = b; nu = c; end
         SECTOR_2: begin nu = a; nv = b; nw = c; end
         SECTOR_3: begin nu = a; nw = b; nv = c; end
         SECTOR_4: begin nw = a; nu = b; nv = c; end
         SECTOR_5: begin nv = a; nu = b; nw = c; end
         SECTOR_6: begin nw = a; nv = b; nu = c; end
         default: ;
      endcase

      phase_u_in        = phase_u_ff;
      phase_v_in        = phase_v_ff;
      phase_w_in        = phase_w_ff;
      delayed_sector_in = delayed_sector_ff;
      if (req_sampling_on) begin
         case (shunt_count_ff)
            SHUNT_SINGLE: begin
               phase_u_in        = slew(nu, phase_u_ff, step_limit_ff);
               phase_v_in        = slew(nv, phase_v_ff, step_limit_ff);
               phase_w_in        = slew(nw, phase_w_ff, step_limit_ff);
               delayed_sector_in = req_sector;
            end
            SHUNT_TWO: begin
               phase_u_in = iu;
               phase_v_in = iv;
               phase_w_in = 16'd0 - iu - iv;
            end
            SHUNT_THREE: begin
               // sectors 2 and 3 rebuild phase u, sectors 1 and 5 phase v, from the other two
               phase_u_in = iu;
               phase_v_in = iv;
               phase_w_in = iw;
               if (req_sector == SECTOR_2 || req_sector == SECTOR_3) begin
                  phase_u_in = 16'd0 - iv - iw;
               end
               if (req_sector == SECTOR_1 || req_sector == SECTOR_5) begin
                  phase_v_in = 16'd0 - iu - iw;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_u_ff        <= '0;
         phase_v_ff        <= '0;
         phase_w_ff        <= '0;
         delayed_sector_ff <= '0;
      end else if (accept) begin
         phase_u_ff        <= phase_u_in;
         phase_v_ff        <= phase_v_in;
         phase_w_ff        <= phase_w_in;
         delayed_sector_ff <= delayed_sector_in;
      end
   end

   always_comb begin
      mid_data.sampling_on = req_sampling_on;
      mid_data.i_u         = phase_u_in;
      mid_data.i_v         = phase_v_in;
      mid_data.i_w         = phase_w_in;
      mid_data.d_current   = req_d_current;
      mid_data.q_current   = req_q_current;
      mid_data.sine        = req_sine;
      mid_data.cosine      = req_cosine;
   end

endmodule

/* hdl/pcrc_back.sv */
`timescale 1ns / 1ps

module pcrc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_empty,
   input  pcrc_pkg::mid_type  mid_data,
   output logic               mid_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic signed [15:0] rsp_i_alpha,
   output logic signed [15:0] rsp_i_beta,
   output logic signed [15:0] rsp_i_u,
   output logic signed [15:0] rsp_i_v,
   output logic signed [15:0] rsp_i_w
);
   import pcrc_pkg::*;

   // multiply stage
   logic               s1_valid_ff;
   logic               s1_on_ff;
   logic signed [15:0] s1_u_ff, s1_v_ff, s1_w_ff;
   logic signed [31:0] m0_ff, m1_ff, m2_ff, m3_ff;
   logic signed [15:0] op_a0, op_b0, op_a1, op_b1;

   // sum and shift
   logic signed [32:0] sum_01, diff_01, sum_23;
   logic signed [32:0] beta_wide;
   rsp_type            rsp_in;

   // result queue
   rsp_type               mem_ff [QueueDepth];
   logic [PtrBits-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CountBits-1:0]  count_ff, count_in;
   logic [CountBits-1:0]  committed;
   logic                  do_pop;

   // room for everything already in the multiply stage
   assign committed = count_ff + CountBits'(s1_valid_ff);
   assign mid_pop   = !mid_empty && (committed < CountBits'(QueueDepth));

   always_comb begin
      op_a0 = mid_data.sampling_on ? mid_data.i_u : mid_data.d_current;
      op_b0 = mid_data.sampling_on ? CLARKE_K1    : mid_data.cosine;
      op_a1 = mid_data.sampling_on ? mid_data.i_v : mid_data.q_current;
      op_b1 = mid_data.sampling_on ? CLARKE_K2    : mid_data.sine;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_pop) begin
         s1_on_ff <= mid_data.sampling_on;
         s1_u_ff  <= mid_data.i_u;
         s1_v_ff  <= mid_data.i_v;
         s1_w_ff  <= mid_data.i_w;
         m0_ff    <= op_a0 * op_b0;
         m1_ff    <= op_a1 * op_b1;
         m2_ff    <= mid_data.d_current * mid_data.sine;
         m3_ff    <= mid_data.q_current * mid_data.cosine;
      end
   end

   always_comb begin
      sum_01  = 33'(m0_ff) + 33'(m1_ff);
      diff_01 = 33'(m0_ff) - 33'(m1_ff);
      sum_23  = 33'(m2_ff) + 33'(m3_ff);
      // arithmetic shift gives the floor
      beta_wide = s1_on_ff ? (sum_01 >>> 14) : (sum_23 >>> 15);
      rsp_in.i_alpha = s1_on_ff ? s1_u_ff : 16'(diff_01 >>> 15);
      rsp_in.i_beta  = beta_wide[15:0];
      rsp_in.i_u     = s1_u_ff;
      rsp_in.i_v     = s1_v_ff;
      rsp_in.i_w     = s1_w_ff;
   end

   assign rsp_empty = (count_ff == '0);
   assign do_pop    = rsp_pop && !rsp_empty;
   assign count_in  = count_ff + CountBits'(s1_valid_ff) - CountBits'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         mem_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   always_comb begin
      rsp_i_alpha = mem_ff[rd_ptr_ff].i_alpha;
      rsp_i_beta  = mem_ff[rd_ptr_ff].i_beta;
      rsp_i_u     = mem_ff[rd_ptr_ff].i_u;
      rsp_i_v     = mem_ff[rd_ptr_ff].i_v;
      rsp_i_w     = mem_ff[rd_ptr_ff].i_w;
   end

endmodule

/* hdl/phase_current_reconstruct_clarke_top.sv */
`timescale 1ns / 1ps
// Path: mid queue, multiply stage, result queue. Throughput: one transaction per cycle
// while full is low; the phase state updates in the accepting cycle
// and the two-multiplier-pair Clarke / inverse Park stage is fully pipelined.
// Reset (synchronous, active high) empties both queues, clears the phase currents and
// delayed sector and loads the register defaults; no clearing pass is needed.
module phase_current_reconstruct_clarke_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               push,
   output logic               full,
   input  logic               req_sampling_on,
   input  logic [11:0]        req_adc_u,
   input  logic [11:0]        req_adc_v,
   input  logic [11:0]        req_adc_w,
   input  logic [11:0]        req_adc_bus_first,
   input  logic [11:0]        req_adc_bus_second,
   input  logic [2:0]         req_sector,
   input  logic signed [15:0] req_d_current,
   input  logic signed [15:0] req_q_current,
   input  logic signed [15:0] req_sine,
   input  logic signed [15:0] req_cosine,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_i_alpha,
   output logic signed [15:0] rsp_i_beta,
   output logic signed [15:0] rsp_i_u,
   output logic signed [15:0] rsp_i_v,
   output logic signed [15:0] rsp_i_w
);
   import pcrc_pkg::*;

   mid_type mid_push_data, mid_pop_data;
   logic    mid_full, mid_empty, mid_pop;
   logic    accept;

   assign full   = mid_full;
   assign accept = push && !mid_full;

   pcrc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .accept             (accept),
      .req_sampling_on    (req_sampling_on),
      .req_adc_u          (req_adc_u),
      .req_adc_v          (req_adc_v),
      .req_adc_w          (req_adc_w),
      .req_adc_bus_first  (req_adc_bus_first),
      .req_adc_bus_second (req_adc_bus_second),
      .req_sector         (req_sector),
      .req_d_current      (req_d_current),
      .req_q_current      (req_q_current),
      .req_sine           (req_sine),
      .req_cosine         (req_cosine),
      .mid_data           (mid_push_data)
   );

   pcrc_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (mid_push_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   pcrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mid_empty   (mid_empty),
      .mid_data    (mid_pop_data),
      .mid_pop     (mid_pop),
      .rsp_pop     (pop),
      .rsp_empty   (empty),
      .rsp_i_alpha (rsp_i_alpha),
      .rsp_i_beta  (rsp_i_beta),
      .rsp_i_u     (rsp_i_u),
      .rsp_i_v     (rsp_i_v),
      .rsp_i_w     (rsp_i_w)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import pcrc_pkg::*;

   localparam logic [2:0] SECTOR_ZERO  = 3'd0;
   localparam logic [2:0] SECTOR_SEVEN = 3'd7;

   typedef struct packed {
      logic               on;
      logic [11:0]        adc_u;
      logic [11:0]        adc_v;
      logic [11:0]        adc_w;
      logic [11:0]        bus_a;
      logic [11:0]        bus_b;
      logic [2:0]         sector;
      logic signed [15:0] d;
      logic signed [15:0] q;
      logic signed [15:0] sn;
      logic signed [15:0] cs;
   } sample_type;

   typedef struct packed {
      logic [1:0] mode;
      sample_type s;
      logic       known;
      rsp_type    want;
   } plan_row_type;

   typedef struct packed {
      logic [1:0]  shunts;
      logic [15:0] u_off;
      logic [15:0] v_off;
      logic [15:0] w_off;
      logic [15:0] bus_off;
      logic [15:0] bus_trim;
      logic [15:0] first_trim;
      logic [14:0] step;
   } settings_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   logic               push = 1'b0;
   logic               full;
   logic               req_sampling_on = 1'b0;
   logic [11:0]        req_adc_u = '0;
   logic [11:0]        req_adc_v = '0;
   logic [11:0]        req_adc_w = '0;
   logic [11:0]        req_adc_bus_first = '0;
   logic [11:0]        req_adc_bus_second = '0;
   logic [2:0]         req_sector = '0;
   logic signed [15:0] req_d_current = '0;
   logic signed [15:0] req_q_current = '0;
   logic signed [15:0] req_sine = '0;
   logic signed [15:0] req_cosine = '0;
   logic               empty;
   logic               pop = 1'b0;
   logic signed [15:0] rsp_i_alpha;
   logic signed [15:0] rsp_i_beta;
   logic signed [15:0] rsp_i_u;
   logic signed [15:0] rsp_i_v;
   logic signed [15:0] rsp_i_w;

   // directed rows with a hand-worked result ride alongside the transaction
   logic    row_known = 1'b0;
   rsp_type row_want = '0;

   bit no_idle = 1'b0;
   bit hold_rx = 1'b0;
   int error_count = 0;

   // predictor copy of the registers and the phase state
   logic [1:0]  cfg_shunts;
   logic [15:0] cfg_u_off, cfg_v_off, cfg_w_off, cfg_bus_off, cfg_bus_trim, cfg_first_trim;
   logic [14:0] cfg_step;
   logic [15:0] phase_u, phase_v, phase_w;
   logic [2:0]  held_sector;

   rsp_type      expected_currents[$];
   plan_row_type plan[$];
   logic [2:0] rot_sector = SECTOR_1;

   phase_current_reconstruct_clarke_top uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .push               (push),
      .full               (full),
      .req_sampling_on    (req_sampling_on),
      .req_adc_u          (req_adc_u),
      .req_adc_v          (req_adc_v),
      .req_adc_w          (req_adc_w),
      .req_adc_bus_first  (req_adc_bus_first),
      .req_adc_bus_second (req_adc_bus_second),
      .req_sector         (req_sector),
      .req_d_current      (req_d_current),
      .req_q_current      (req_q_current),
      .req_sine           (req_sine),
      .req_cosine         (req_cosine),
      .empty              (empty),
      .pop                (pop),
      .rsp_i_alpha        (rsp_i_alpha),
      .rsp_i_beta         (rsp_i_beta),
      .rsp_i_u            (rsp_i_u),
      .rsp_i_v            (rsp_i_v),
      .rsp_i_w            (rsp_i_w)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_error(input string msg);
      if (error_count < 100) $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [15:0] limit_step(input logic [15:0] target,
                                              input logic [15:0] prev);
      logic signed [15:0] delta;
      int                 lim;
      delta = target - prev;
      lim   = int'(cfg_step);
      if (int'(delta) > lim) return prev + {1'b0, cfg_step};
      if (int'(delta) < -lim) return prev - {1'b0, cfg_step};
      return target;
   endfunction

   function automatic logic [15:0] clarke_beta(input logic [15:0] u, input logic [15:0] v);
      longint acc;
      acc = longint'($signed(u)) * CLARKE_K1 + longint'($signed(v)) * CLARKE_K2;
      acc = acc >>> 14;
      return acc[15:0];
   endfunction

   function automatic logic [15:0] park_term(input logic signed [15:0] a,
                                             input logic signed [15:0] b,
                                             input logic signed [15:0] c,
                                             input logic signed [15:0] e,
                                             input bit subtract);
      longint acc;
      acc = subtract ? longint'(a) * longint'(b) - longint'(c) * longint'(e)
                     : longint'(a) * longint'(b) + longint'(c) * longint'(e);
      acc = acc >>> 15;
      return acc[15:0];
   endfunction

   task automatic predict_currents(input sample_type s, output rsp_type r);
      logic [15:0] t0, t1, fa, fb, fc, nu, nv, nw, iu, iv, iw;
      if (s.on) begin
         case (cfg_shunts)
            SHUNT_SINGLE: begin
               t0 = {s.bus_a, 4'h0} - cfg_bus_off - cfg_bus_trim;
               t1 = {s.bus_b, 4'h0} - cfg_bus_off - cfg_bus_trim;
               fa = t0 - cfg_first_trim;
               fb = 16'h0 - t1;
               fc = t1 - t0;
               nu = '0;
               nv = '0;
               nw = '0;
               // the map follows the sector of the previous sample set
               case (held_sector)
                  SECTOR_1: begin nv = fa; nw = fb; nu = fc; end
                  SECTOR_2: begin nu = fa; nv = fb; nw = fc; end
                  SECTOR_3: begin nu = fa; nw = fb; nv = fc; end
                  SECTOR_4: begin nw = fa; nu = fb; nv = fc; end
                  SECTOR_5: begin nv = fa; nu = fb; nw = fc; end
                  SECTOR_6: begin nw = fa; nv = fb; nu = fc; end
                  default: ;
               endcase
               phase_u = limit_step(nu, phase_u);
               phase_v = limit_step(nv, phase_v);
               phase_w = limit_step(nw, phase_w);
               held_sector = s.sector;
            end
            SHUNT_TWO: begin
               phase_u = cfg_u_off - {s.adc_u, 4'h0};
               phase_v = cfg_v_off - {s.adc_v, 4'h0};
               phase_w = 16'h0 - phase_u - phase_v;
            end
            SHUNT_THREE: begin
               iu = cfg_u_off - {s.adc_u, 4'h0};
               iv = cfg_v_off - {s.adc_v, 4'h0};
               iw = cfg_w_off - {s.adc_w, 4'h0};
               if (s.sector == SECTOR_2 || s.sector == SECTOR_3) iu = 16'h0 - iv - iw;
               if (s.sector == SECTOR_1 || s.sector == SECTOR_5) iv = 16'h0 - iu - iw;
               phase_u = iu;
               phase_v = iv;
               phase_w = iw;
            end
            default: ;
         endcase
         r.i_alpha = phase_u;
         r.i_beta  = clarke_beta(phase_u, phase_v);
      end else begin
         r.i_alpha = park_term(s.d, s.cs, s.q, s.sn, 1'b1);
         r.i_beta  = park_term(s.d, s.sn, s.q, s.cs, 1'b0);
      end
      r.i_u = phase_u;
      r.i_v = phase_v;
      r.i_w = phase_w;
   endtask

   // register writes and accepted transactions, in handshake order
   always @(posedge clock) begin : predictor
      sample_type s;
      rsp_type    r;
      if (reset) begin
         cfg_shunts     <= SHUNT_THREE;
         cfg_u_off      = '0;
         cfg_v_off      = '0;
         cfg_w_off      = '0;
         cfg_bus_off    = '0;
         cfg_bus_trim   = 16'd300;
         cfg_first_trim = 16'hFF9C;
         cfg_step       = 15'd512;
         phase_u        = '0;
         phase_v        = '0;
         phase_w        = '0;
         held_sector    = SECTOR_ZERO;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHUNT_COUNT: cfg_shunts     <= csr_data[1:0];
               CSR_U_OFFSET:    cfg_u_off      = csr_data;
               CSR_V_OFFSET:    cfg_v_off      = csr_data;
               CSR_W_OFFSET:    cfg_w_off      = csr_data;
               CSR_BUS_OFFSET:  cfg_bus_off    = csr_data;
               CSR_BUS_TRIM:    cfg_bus_trim   = csr_data;
               CSR_FIRST_TRIM:  cfg_first_trim = csr_data;
               CSR_STEP_LIMIT:  cfg_step       = csr_data[14:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            s = '{req_sampling_on, req_adc_u, req_adc_v, req_adc_w, req_adc_bus_first,
                  req_adc_bus_second, req_sector, req_d_current, req_q_current,
                  req_sine, req_cosine};
            predict_currents(s, r);
            expected_currents.push_back(row_known ? row_want : r);
         end
      end
   end

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0d expected %0d", name, $signed(got), $signed(want)));
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_currents.size() == 0) begin
            flag_error($sformatf("unexpected transaction, alpha %0d", rsp_i_alpha));
         end else begin
            want = expected_currents.pop_front();
            check_field("i_alpha", rsp_i_alpha, want.i_alpha);
            check_field("i_beta", rsp_i_beta, want.i_beta);
            check_field("i_u", rsp_i_u, want.i_u);
            check_field("i_v", rsp_i_v, want.i_v);
            check_field("i_w", rsp_i_w, want.i_w);
         end
      end
   end

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   initial begin : receiver
      while (reset) @(posedge clock);
      forever begin
         if (hold_rx) begin
            // back-pressure long enough to fill the block and stall its input
            pop <= 1'b0;
            repeat (80) @(posedge clock);
            hold_rx = 1'b0;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat (gap_length()) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send(input sample_type s, input logic known, input rsp_type want);
      if (!no_idle && !hold_rx && $urandom_range(0, 2) == 0) begin
         push <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
      req_sampling_on    <= s.on;
      req_adc_u          <= s.adc_u;
      req_adc_v          <= s.adc_v;
      req_adc_w          <= s.adc_w;
      req_adc_bus_first  <= s.bus_a;
      req_adc_bus_second <= s.bus_b;
      req_sector         <= s.sector;
      req_d_current      <= s.d;
      req_q_current      <= s.q;
      req_sine           <= s.sn;
      req_cosine         <= s.cs;
      row_known          <= known;
      row_want           <= want;
      push               <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic settle();
      push <= 1'b0;
      while (expected_currents.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_all(input settings_type c);
      csr_write(CSR_SHUNT_COUNT, {14'h0, c.shunts});
      csr_write(CSR_U_OFFSET, c.u_off);
      csr_write(CSR_V_OFFSET, c.v_off);
      csr_write(CSR_W_OFFSET, c.w_off);
      csr_write(CSR_BUS_OFFSET, c.bus_off);
      csr_write(CSR_BUS_TRIM, c.bus_trim);
      csr_write(CSR_FIRST_TRIM, c.first_trim);
      csr_write(CSR_STEP_LIMIT, {1'b0, c.step});
      csr_valid <= 1'b0;
   endtask

   task automatic row(input logic [1:0] mode, input logic on,
                      input logic [11:0] au, input logic [11:0] av, input logic [11:0] aw,
                      input logic [11:0] b0, input logic [11:0] b1, input logic [2:0] sec,
                      input logic signed [15:0] d, input logic signed [15:0] q,
                      input logic signed [15:0] sn, input logic signed [15:0] cs,
                      input logic known, input rsp_type want);
      plan_row_type p;
      p.mode  = mode;
      p.s     = '{on, au, av, aw, b0, b1, sec, d, q, sn, cs};
      p.known = known;
      p.want  = want;
      plan.push_back(p);
   endtask

   function automatic logic [11:0] adc_sample();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return 12'h000;
      if (r < 10) return 12'hFFF;
      if (r < 80) return 12'(2048 + $urandom_range(0, 800) - 400);
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [15:0] offset_value();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'(32768 + $urandom_range(0, 2000) - 1000);
   endfunction

   function automatic settings_type pick_settings(input int phase);
      settings_type c;
      int unsigned  r;
      c.u_off      = offset_value();
      c.v_off      = offset_value();
      c.w_off      = offset_value();
      c.bus_off    = offset_value();
      c.bus_trim   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 600) - 300);
      c.first_trim = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 400) - 200);
      r = $urandom_range(0, 9);
      c.step = (r == 0) ? 15'd0 : (r < 3) ? 15'($urandom) : 15'($urandom_range(64, 4096));
      r = $urandom_range(0, 9);
      c.shunts = (r < 5) ? SHUNT_SINGLE : (r < 7) ? SHUNT_THREE : (r < 9) ? SHUNT_TWO
                                                                        : SHUNT_NONE;
      case (phase)
         0: c = '{SHUNT_SINGLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h8000, 16'h8000, 15'h0000};
         1: c = '{SHUNT_SINGLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'h7FFF, 16'h7FFF, 15'h7FFF};
         2: c.shunts = SHUNT_THREE;
         3: c.shunts = SHUNT_NONE;
         4: c.shunts = SHUNT_TWO;
         default: ;
      endcase
      return c;
   endfunction

   // mostly a rotating sector sequence, with the odd jump or invalid sector
   function automatic sample_type random_sample();
      sample_type  s;
      int unsigned r;
      s.on     = ($urandom_range(0, 99) >= 12);
      s.adc_u  = adc_sample();
      s.adc_v  = adc_sample();
      s.adc_w  = adc_sample();
      s.bus_a  = adc_sample();
      s.bus_b  = adc_sample();
      s.d      = 16'($urandom);
      s.q      = 16'($urandom);
      s.sn     = 16'($urandom);
      s.cs     = 16'($urandom);
      r = $urandom_range(0, 19);
      if (r == 0)
         rot_sector = 3'($urandom_range(0, 7));
      else if (r == 1)
         rot_sector = (rot_sector <= SECTOR_1 || rot_sector > SECTOR_6) ? SECTOR_6
                                                                          : rot_sector - 3'd1;
      else
         rot_sector = (rot_sector >= SECTOR_6 || rot_sector == SECTOR_ZERO) ? SECTOR_1
                                                                             : rot_sector + 3'd1;
      s.sector = rot_sector;
      return s;
   endfunction

   initial begin : stimulus
      logic [1:0]   cur_mode;
      settings_type c;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      row(SHUNT_THREE, 1, 0, 0, 0, 0, 0, SECTOR_4, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0});
      row(SHUNT_THREE, 1, 4095, 0, 0, 0, 0, SECTOR_4, 0, 0, 0, 0, 1, '{16, 9, 16, 0, 0});
      row(SHUNT_THREE, 1, 4095, 4095, 4095, 4095, 4095, SECTOR_6, 0, 0, 0, 0,
          1, '{16, 27, 16, 16, 16});
      row(SHUNT_THREE, 0, 0, 0, 0, 0, 0, SECTOR_4, -32768, 0, 0, -32768,
          1, '{-32768, 0, 16, 16, 16});
      row(SHUNT_THREE, 0, 4095, 4095, 4095, 4095, 4095, SECTOR_1, 32767, -32768, 32767,
          32767, 0, '0);
      row(SHUNT_THREE, 1, 1000, 3000, 2048, 0, 0, SECTOR_2, 0, 0, 0, 0, 0, '0);
      row(SHUNT_THREE, 1, 0, 4095, 100, 0, 0, SECTOR_3, 0, 0, 0, 0, 0, '0);
      row(SHUNT_THREE, 1, 2100, 0, 4095, 0, 0, SECTOR_1, 0, 0, 0, 0, 0, '0);
      row(SHUNT_THREE, 1, 4095, 1500, 0, 0, 0, SECTOR_5, 0, 0, 0, 0, 0, '0);
      row(SHUNT_THREE, 1, 1, 2, 3, 0, 0, SECTOR_ZERO, 0, 0, 0, 0, 0, '0);
      row(SHUNT_THREE, 1, 4094, 2049, 2047, 0, 0, SECTOR_SEVEN, 0, 0, 0, 0, 0, '0);
      row(SHUNT_TWO, 1, 0, 4095, 1234, 0, 0, SECTOR_3, 0, 0, 0, 0, 0, '0);
      row(SHUNT_TWO, 1, 4095, 4095, 0, 0, 0, SECTOR_2, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 4095, 0, SECTOR_1, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 0, 4095, SECTOR_2, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 2300, 1800, SECTOR_3, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 4095, 4095, SECTOR_4, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 0, 0, SECTOR_5, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 1900, 2200, SECTOR_6, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 2500, 1500, SECTOR_SEVEN, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 2500, 1500, SECTOR_ZERO, 0, 0, 0, 0, 0, '0);
      row(SHUNT_SINGLE, 1, 0, 0, 0, 2500, 1500, SECTOR_1, 0, 0, 0, 0, 0, '0);
      row(SHUNT_NONE, 1, 4095, 4095, 4095, 4095, 4095, SECTOR_2, 0, 0, 0, 0, 0, '0);
      row(SHUNT_NONE, 0, 0, 0, 0, 0, 0, SECTOR_ZERO, 32767, 32767, -32768, -32768, 0, '0);

      cur_mode = SHUNT_THREE;
      foreach (plan[i]) begin
         if (plan[i].mode != cur_mode) begin
            settle();
            csr_write(CSR_SHUNT_COUNT, {14'h0, plan[i].mode});
            csr_valid <= 1'b0;
            cur_mode = plan[i].mode;
         end
         send(plan[i].s, plan[i].known, plan[i].want);
      end

      for (int phase = 0; phase < 10; phase++) begin
         settle();
         c = pick_settings(phase);
         program_all(c);
         no_idle = (phase % 3 == 1);
         if (phase == 2) hold_rx = 1'b1;
         for (int n = 0; n < 103; n++) send(random_sample(), 1'b0, '0);
      end

      settle();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/pcrc_pkg.sv
hdl/pcrc_mid_queue.sv
hdl/pcrc_front.sv
hdl/pcrc_back.sv
hdl/phase_current_reconstruct_clarke_top.sv
verif/testbench.sv
